### rtl/multi_queue_ticket_order_defines.svh
// ----------------------------------------------------------------------------
// multi_queue_ticket_order_defines.svh
// Assertion macros shared by the ticket order block.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_TICKET_ORDER_DEFINES_SVH
`define MULTI_QUEUE_TICKET_ORDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQTO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MQTO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mqto_pkg.sv
// ----------------------------------------------------------------------------
// mqto_pkg
// Types and constants shared by the ticket order controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mqto_pkg;

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TICKET_W        = 32;
  localparam int QID_W           = 4;
  localparam int CMD_W           = 2;
  localparam int CFG_W           = 4;
  localparam logic [CFG_W-1:0] QUEUES_IN_USE_RST = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ISSUE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_DONE  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_IDX,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    issue;
    logic    clear;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    idx_clr;
    logic    idx_inc;
    logic    dec_fill;
    logic    finish;
  } ctl_t;

  typedef struct packed {
    logic valid;
    logic srch_end;
    logic shift_end;
    logic match;
  } stat_t;

endpackage

`default_nettype wire

### rtl/mqto_ram.sv
// ----------------------------------------------------------------------------
// mqto_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mqto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/mqto_ctrl.sv
// ----------------------------------------------------------------------------
// mqto_ctrl
// Controller state machine: sequences issue, query, retire and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module mqto_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [mqto_pkg::CMD_W-1:0]         in_cmd,
  input  wire mqto_pkg::stat_t                    stat,
  output mqto_pkg::ctl_t                          ctl,
  output logic                                    busy
);

  mqto_pkg::state_t state_r;
  mqto_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mqto_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.rd_sel   = mqto_pkg::RD_HEAD;
    case (state_r)
      mqto_pkg::ST_IDLE: begin
        if (start) begin
          ctl.load_in = 1'b1;
          case (mqto_pkg::cmd_t'(in_cmd))
            mqto_pkg::CMD_ISSUE: begin
              ctl.issue  = 1'b1;
              ctl.finish = 1'b1;
            end
            mqto_pkg::CMD_QUERY: begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = mqto_pkg::RD_HEAD;
              state_nxt  = mqto_pkg::ST_QUERY;
            end
            mqto_pkg::CMD_DONE: begin
              ctl.idx_clr = 1'b1;
              state_nxt   = mqto_pkg::ST_SRCH_RD;
            end
            default: begin
              ctl.clear  = 1'b1;
              ctl.finish = 1'b1;
            end
          endcase
        end
      end
      mqto_pkg::ST_QUERY: begin
        ctl.finish = 1'b1;
        state_nxt  = mqto_pkg::ST_IDLE;
      end
      mqto_pkg::ST_SRCH_RD: begin
        if (!stat.valid || stat.srch_end) begin
          ctl.finish = 1'b1;
          state_nxt  = mqto_pkg::ST_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = mqto_pkg::RD_IDX;
          state_nxt  = mqto_pkg::ST_SRCH_CMP;
        end
      end
      mqto_pkg::ST_SRCH_CMP: begin
        if (stat.match) begin
          state_nxt = mqto_pkg::ST_SHIFT_RD;
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt   = mqto_pkg::ST_SRCH_RD;
        end
      end
      mqto_pkg::ST_SHIFT_RD: begin
        if (stat.shift_end) begin
          ctl.dec_fill = 1'b1;
          ctl.finish   = 1'b1;
          state_nxt    = mqto_pkg::ST_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = mqto_pkg::RD_NEXT;
          state_nxt  = mqto_pkg::ST_SHIFT_WR;
        end
      end
      mqto_pkg::ST_SHIFT_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.idx_inc  = 1'b1;
        state_nxt    = mqto_pkg::ST_SHIFT_RD;
      end
      default: begin
        state_nxt = mqto_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != mqto_pkg::ST_IDLE);

endmodule

`default_nettype wire

### rtl/mqto_dpath.sv
// ----------------------------------------------------------------------------
// mqto_dpath
// Datapath: ticket counter, fill counts, queue entry RAM and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_queue_ticket_order_defines.svh"

module mqto_dpath #(
  parameter int NUM_QUEUES  = mqto_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqto_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mqto_pkg::ctl_t                  ctl,
  output mqto_pkg::stat_t                      stat,
  input  wire logic [mqto_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [mqto_pkg::QID_W-1:0]      in_queue_id,
  input  wire logic [mqto_pkg::TICKET_W-1:0]   in_ticket,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mqto_pkg::CFG_W-1:0]      cfg_wr_data,
  output logic                                 out_valid,
  output logic      [mqto_pkg::TICKET_W-1:0]   out_new_ticket,
  output logic                                 out_waiting,
  output logic                                 out_queue_empty,
  output logic                                 out_queue_valid,
  output logic                                 out_overflow
);

  localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW        = $clog2(QUEUE_DEPTH);
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);
  localparam int AW        = QW + IW;
  localparam int RAM_DEPTH = 1 << AW;
  localparam int TW        = mqto_pkg::TICKET_W;

  // Latched request.
  mqto_pkg::cmd_t              cmd_r,    cmd_nxt;
  logic [mqto_pkg::QID_W-1:0]  q_r,      q_nxt;
  logic [TW-1:0]               ticket_r, ticket_nxt;
  logic                        valid_r,  valid_nxt;
  logic [FW-1:0]               idx_r,    idx_nxt;

  // Block state.
  logic [TW-1:0]               counter_r, counter_nxt;
  logic [FW-1:0]               fill_r   [NUM_QUEUES];
  logic [FW-1:0]               fill_nxt [NUM_QUEUES];
  logic [mqto_pkg::CFG_W-1:0]  qiu_r,     qiu_nxt;

  // Result registers.
  logic                        out_valid_r,   out_valid_nxt;
  logic [TW-1:0]               out_ticket_r,  out_ticket_nxt;
  logic                        out_waiting_r, out_waiting_nxt;
  logic                        out_empty_r,   out_empty_nxt;
  logic                        out_qvalid_r,  out_qvalid_nxt;
  logic                        out_ovf_r,     out_ovf_nxt;

  mqto_pkg::cmd_t              cmd_sel;
  logic [mqto_pkg::QID_W-1:0]  q_sel;
  logic [QW-1:0]               qi;
  logic                        valid_in;
  logic                        valid_sel;
  logic [FW-1:0]               fill_cur;
  logic [FW-1:0]               post_fill;
  logic                        full;
  logic                        store;
  logic [FW-1:0]               idx_p1;
  logic [TW-1:0]               counter_inc;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [TW-1:0]               ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [TW-1:0]               ram_rdata;

  // A queue is addressable when it is below both the register and the build size.
  assign valid_in  = (in_queue_id < qiu_r) &&
                     ((mqto_pkg::QID_W + 1)'(in_queue_id) < (mqto_pkg::QID_W + 1)'(NUM_QUEUES));

  assign cmd_sel   = ctl.load_in ? mqto_pkg::cmd_t'(in_cmd) : cmd_r;
  assign q_sel     = ctl.load_in ? in_queue_id : q_r;
  assign valid_sel = ctl.load_in ? valid_in : valid_r;
  assign qi        = q_sel[QW-1:0];
  assign fill_cur  = valid_sel ? fill_r[qi] : '0;
  assign full      = (fill_cur == FW'(QUEUE_DEPTH));
  assign store     = ctl.issue && valid_sel && !full;
  assign idx_p1    = idx_r + FW'(1);
  assign counter_inc = counter_r + TW'(1);

  always_comb begin
    if (ctl.clear) begin
      post_fill = '0;
    end else if (store) begin
      post_fill = fill_cur + FW'(1);
    end else if (ctl.dec_fill) begin
      post_fill = fill_cur - FW'(1);
    end else begin
      post_fill = fill_cur;
    end
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    q_nxt      = q_r;
    ticket_nxt = ticket_r;
    valid_nxt  = valid_r;
    if (ctl.load_in) begin
      cmd_nxt    = mqto_pkg::cmd_t'(in_cmd);
      q_nxt      = in_queue_id;
      ticket_nxt = in_ticket;
      valid_nxt  = valid_in;
    end

    if (ctl.idx_clr) begin
      idx_nxt = '0;
    end else if (ctl.idx_inc) begin
      idx_nxt = idx_p1;
    end else begin
      idx_nxt = idx_r;
    end

    if (ctl.clear) begin
      counter_nxt = '0;
    end else if (ctl.issue) begin
      counter_nxt = counter_inc;
    end else begin
      counter_nxt = counter_r;
    end

    for (int i = 0; i < NUM_QUEUES; i++) begin
      fill_nxt[i] = ctl.clear ? '0 : fill_r[i];
    end
    if (valid_sel && (store || ctl.dec_fill)) begin
      fill_nxt[qi] = post_fill;
    end

    qiu_nxt = cfg_wr_en ? cfg_wr_data : qiu_r;
  end

  // Result formation on the last cycle of each transaction.
  always_comb begin
    out_valid_nxt   = ctl.finish;
    out_ticket_nxt  = out_ticket_r;
    out_waiting_nxt = out_waiting_r;
    out_empty_nxt   = out_empty_r;
    out_qvalid_nxt  = out_qvalid_r;
    out_ovf_nxt     = out_ovf_r;
    if (ctl.finish) begin
      out_ticket_nxt  = ctl.issue ? counter_inc : '0;
      out_waiting_nxt = (cmd_sel == mqto_pkg::CMD_QUERY) && valid_sel &&
                        (fill_cur != '0) && (ram_rdata != ticket_r);
      out_empty_nxt   = !valid_sel || (post_fill == '0);
      out_qvalid_nxt  = valid_sel;
      out_ovf_nxt     = ctl.issue && valid_sel && full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      counter_r   <= '0;
      qiu_r       <= mqto_pkg::QUEUES_IN_USE_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      valid_r     <= valid_nxt;
      counter_r   <= counter_nxt;
      qiu_r       <= qiu_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    q_r           <= q_nxt;
    ticket_r      <= ticket_nxt;
    idx_r         <= idx_nxt;
    out_ticket_r  <= out_ticket_nxt;
    out_waiting_r <= out_waiting_nxt;
    out_empty_r   <= out_empty_nxt;
    out_qvalid_r  <= out_qvalid_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  // Entry RAM: queue number in the upper address bits, slot in the lower.
  always_comb begin
    ram_we    = store || ctl.wr_shift;
    ram_waddr = ctl.wr_shift ? {q_r[QW-1:0], idx_r[IW-1:0]}
                             : {in_queue_id[QW-1:0], fill_cur[IW-1:0]};
    ram_wdata = ctl.wr_shift ? ram_rdata : counter_inc;
    case (ctl.rd_sel)
      mqto_pkg::RD_HEAD: ram_raddr = {in_queue_id[QW-1:0], IW'(0)};
      mqto_pkg::RD_IDX:  ram_raddr = {q_r[QW-1:0], idx_r[IW-1:0]};
      mqto_pkg::RD_NEXT: ram_raddr = {q_r[QW-1:0], idx_p1[IW-1:0]};
      default:           ram_raddr = {in_queue_id[QW-1:0], IW'(0)};
    endcase
  end

  mqto_ram #(
    .WIDTH (TW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ctl.rd_en),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign stat.valid     = valid_r;
  assign stat.srch_end  = (idx_r >= fill_cur);
  assign stat.shift_end = (idx_p1 >= fill_cur);
  assign stat.match     = (ram_rdata == ticket_r);

  assign out_valid       = out_valid_r;
  assign out_new_ticket  = out_ticket_r;
  assign out_waiting     = out_waiting_r;
  assign out_queue_empty = out_empty_r;
  assign out_queue_valid = out_qvalid_r;
  assign out_overflow    = out_ovf_r;

  // A queue that overflowed is full, so it cannot also read as empty.
  `MQTO_ASSERT_IMP(a_ovf_not_empty, clk, rst_n, out_valid_r && out_ovf_r, !out_empty_r, "overflow reported on an empty queue")
  // A blocked ticket implies a valid, non-empty queue.
  `MQTO_ASSERT_IMP(a_wait_needs_queue, clk, rst_n, out_valid_r && out_waiting_r, out_qvalid_r && !out_empty_r, "waiting reported without a valid non-empty queue")
  // Every finished transaction produces exactly one result strobe.
  `MQTO_ASSERT_NXT(a_finish_strobe, clk, rst_n, ctl.finish, out_valid_r, "finished transaction without a result strobe")
  // The fill count of the latched queue never exceeds the queue depth.
  `MQTO_ASSERT_IMP(a_fill_bound, clk, rst_n, valid_r, fill_r[q_r[QW-1:0]] <= FW'(QUEUE_DEPTH), "queue fill count above depth")

endmodule

`default_nettype wire

### rtl/multi_queue_ticket_order.sv
// A retire walks the queue through the single read port of the entry RAM: each
// entry searched takes a read and a compare state, and each entry shifted
// forward to close the gap takes a read and a write state. A result
// appears on the out_ ports in the cycle after the last work cycle; the
// next transaction may start in that same cycle. The receiver cannot stall.
// Synchronous active-low reset empties all queues and zeroes the counter.
// ----------------------------------------------------------------------------
// multi_queue_ticket_order
// Several small ordered ticket queues sharing one wrapping ticket counter.
// ----------------------------------------------------------------------------
`default_nettype none

// A transaction is accepted when start is high while busy is low. The command
// selects one of four operations:
//   issue - increments the counter and returns the new ticket; the ticket is
//           appended to the addressed queue when the queue is valid and has
//           room; overflow flags a valid queue that is full.
//   query - flags waiting when a non-empty queue's head is not the ticket.
//   done  - removes the first matching ticket, searching from the head, and
//           moves later entries forward by one.
//   clear - empties every queue and zeroes the counter.
// The controller sequences the multi-cycle operations and the datapath holds
// the counter, the per-queue fill counts, the entry RAM and the result
// registers. Entry values are only used below a queue's fill count, so the
// RAM needs no initialization. The user must write the queues_in_use
// register through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block does not enforce this. Queue contents survive a change of it.
module multi_queue_ticket_order #(
  parameter int NUM_QUEUES  = mqto_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqto_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [mqto_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [mqto_pkg::QID_W-1:0]      in_queue_id,
  input  wire logic [mqto_pkg::TICKET_W-1:0]   in_ticket,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mqto_pkg::CFG_W-1:0]      cfg_wr_data,
  output logic                                 out_valid,
  output logic      [mqto_pkg::TICKET_W-1:0]   out_new_ticket,
  output logic                                 out_waiting,
  output logic                                 out_queue_empty,
  output logic                                 out_queue_valid,
  output logic                                 out_overflow
);

  // Command and status buses between the controller and the datapath.
  mqto_pkg::ctl_t  ctl;
  mqto_pkg::stat_t stat;

  // The controller decodes the accepted command and steps through the search
  // and shift phases of a retire, at most one RAM access per state.
  mqto_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy)
  );

  // The datapath latches the request, owns all block state and forms the
  // result registers on the final cycle of every transaction.
  mqto_dpath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_queue_id     (in_queue_id),
    .in_ticket       (in_ticket),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_new_ticket  (out_new_ticket),
    .out_waiting     (out_waiting),
    .out_queue_empty (out_queue_empty),
    .out_queue_valid (out_queue_valid),
    .out_overflow    (out_overflow)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_queue_ticket_order. A cycle-free predictor
// tracks the ticket counter, the per-queue fill counts and the queue entries.
// It produces the reply to every accepted command. Each strobed reply is
// compared field by field with the oldest prediction. A short directed part
// covers ordering, full and invalid queues and the queue count register.
// Random traffic then runs under several queue counts with bursty starts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ = mqto_pkg::NUM_QUEUES_DEF;
  localparam int QD = mqto_pkg::QUEUE_DEPTH_DEF;

  // One reply of the block, in the order the result ports carry it.
  typedef struct packed {
    logic [mqto_pkg::TICKET_W-1:0] new_ticket;
    logic                          waiting;
    logic                          queue_empty;
    logic                          queue_valid;
    logic                          overflow;
  } reply_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [mqto_pkg::CMD_W-1:0]    in_cmd = mqto_pkg::CMD_ISSUE;
  logic [mqto_pkg::QID_W-1:0]    in_queue_id = '0;
  logic [mqto_pkg::TICKET_W-1:0] in_ticket = '0;
  logic                          cfg_wr_en = 1'b0;
  logic [mqto_pkg::CFG_W-1:0]    cfg_wr_data = '0;
  logic                          out_valid;
  logic [mqto_pkg::TICKET_W-1:0] out_new_ticket;
  logic                          out_waiting;
  logic                          out_queue_empty;
  logic                          out_queue_valid;
  logic                          out_overflow;

  multi_queue_ticket_order dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_queue_id     (in_queue_id),
    .in_ticket       (in_ticket),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_new_ticket  (out_new_ticket),
    .out_waiting     (out_waiting),
    .out_queue_empty (out_queue_empty),
    .out_queue_valid (out_queue_valid),
    .out_overflow    (out_overflow)
  );

  // 12 ns clock, low for the first half period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: a private copy of everything the block remembers.
  logic [mqto_pkg::TICKET_W-1:0] ticket_count_m;
  logic [mqto_pkg::TICKET_W-1:0] slot_m [NQ][QD];
  int unsigned                   fill_m [NQ];
  logic [mqto_pkg::CFG_W-1:0]    queues_in_use_m;

  // Replies predicted for accepted transactions, oldest first.
  reply_t expected_replies [$];

  int mismatch_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int overflow_count = 0;
  int waiting_count = 0;
  int cfg_write_count = 0;
  int burst_left = 0;

  // A queue number is live when it is below both the register and the
  // number of queues built; register values above that are clipped.
  function automatic logic queue_reachable(input logic [mqto_pkg::QID_W-1:0] qid);
    return (int'(qid) < int'(queues_in_use_m)) && (int'(qid) < NQ);
  endfunction

  // Applies one command to the predictor state and returns the reply the
  // block must produce for it.
  function automatic reply_t predict_ticket_op(input mqto_pkg::cmd_t op,
                                               input logic [mqto_pkg::QID_W-1:0] qid,
                                               input logic [mqto_pkg::TICKET_W-1:0] tk);
    reply_t r;
    logic   live;
    int     hit;
    r    = '0;
    live = queue_reachable(qid);
    hit  = -1;
    case (op)
      mqto_pkg::CMD_ISSUE: begin
        // The counter advances even when the ticket cannot be stored.
        ticket_count_m = ticket_count_m + 1'b1;
        r.new_ticket = ticket_count_m;
        if (live) begin
          if (fill_m[qid] >= QD) begin
            r.overflow = 1'b1;
          end else begin
            slot_m[qid][fill_m[qid]] = ticket_count_m;
            fill_m[qid]++;
          end
        end
      end
      mqto_pkg::CMD_QUERY: begin
        if (live && fill_m[qid] != 0) begin
          r.waiting = (slot_m[qid][0] != tk);
        end
      end
      mqto_pkg::CMD_DONE: begin
        // Remove the first match from the head and close the gap behind it.
        if (live) begin
          for (int i = 0; i < int'(fill_m[qid]); i++) begin
            if (hit < 0 && slot_m[qid][i] == tk) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            for (int j = hit; j + 1 < int'(fill_m[qid]); j++) begin
              slot_m[qid][j] = slot_m[qid][j+1];
            end
            fill_m[qid]--;
          end
        end
      end
      default: begin
        ticket_count_m = '0;
        for (int i = 0; i < NQ; i++) begin
          fill_m[i] = 0;
        end
      end
    endcase
    r.queue_valid = live;
    r.queue_empty = live ? (fill_m[qid] == 0) : 1'b1;
    return r;
  endfunction

  // Picks a ticket that is likely to be held somewhere, so that queries and
  // retires mostly hit real entries, with head-of-queue tickets favored.
  function automatic logic [mqto_pkg::TICKET_W-1:0] pick_known_ticket(
      input logic [mqto_pkg::QID_W-1:0] qid);
    int roll;
    int other;
    roll  = $urandom_range(99);
    other = $urandom_range(NQ-1);
    if (queue_reachable(qid) && fill_m[qid] != 0 && roll < 70) begin
      if (roll < 30) begin
        return slot_m[qid][0];
      end
      return slot_m[qid][$urandom_range(fill_m[qid]-1)];
    end
    if (fill_m[other] != 0 && roll < 85) begin
      return slot_m[other][$urandom_range(fill_m[other]-1)];
    end
    return $urandom();
  endfunction

  // Presents one command at the falling edge and holds it until a rising
  // edge finds busy low; that edge accepts the transaction. start is left
  // high so a following command can go out back to back; every other caller
  // lowers it at the next falling edge.
  task automatic send_op(input mqto_pkg::cmd_t op, input logic [mqto_pkg::QID_W-1:0] qid,
                         input logic [mqto_pkg::TICKET_W-1:0] tk);
    @(negedge clk);
    start       <= 1'b1;
    in_cmd      <= op;
    in_queue_id <= qid;
    in_ticket   <= tk;
    do @(posedge clk); while (busy !== 1'b0);
    expected_replies.insert(expected_replies.size(), predict_ticket_op(op, qid, tk));
    sent_count++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // The sender works in bursts; between bursts start stays low for a while.
  // Long bursts give stretches of back-to-back traffic.
  task automatic pace_sender();
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Stops issuing and waits until every predicted reply has come back. Each
  // command has exactly one reply, so the block is idle once that happens.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Writes the queue count register while the block is idle.
  task automatic write_queue_count(input logic [mqto_pkg::CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    queues_in_use_m = value;
    cfg_write_count++;
  endtask

  task automatic check_field(input string name, input logic [mqto_pkg::TICKET_W-1:0] want,
                             input logic [mqto_pkg::TICKET_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Reply checker. A strobe lasts one cycle and cannot be held off, so
  // every rising edge with out_valid high carries one reply to compare.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_replies.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none actual ticket %0h",
                 $time, out_new_ticket);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("new_ticket", want.new_ticket, out_new_ticket);
        check_field("waiting", want.waiting, out_waiting);
        check_field("queue_empty", want.queue_empty, out_queue_empty);
        check_field("queue_valid", want.queue_valid, out_queue_valid);
        check_field("overflow", want.overflow, out_overflow);
        checked_count++;
        if (want.overflow) overflow_count++;
        if (want.waiting) waiting_count++;
      end
    end
  end

  // Ordering within one queue: head and non-head queries, retiring from the
  // middle, a retire that matches nothing, and retiring the head. Ends with
  // commands to a queue number that the register leaves unused, where an
  // issue still spends a ticket but stores nothing.
  task automatic test_single_queue_order();
    send_op(mqto_pkg::CMD_QUERY, 4'd0, 32'd0);
    send_op(mqto_pkg::CMD_ISSUE, 4'd0, 32'hFFFF_FFFF);
    send_op(mqto_pkg::CMD_ISSUE, 4'd0, 32'h0000_0000);
    send_op(mqto_pkg::CMD_ISSUE, 4'd0, 32'hA5A5_5A5A);
    send_op(mqto_pkg::CMD_QUERY, 4'd0, 32'd1);
    send_op(mqto_pkg::CMD_QUERY, 4'd0, 32'd3);
    send_op(mqto_pkg::CMD_DONE,  4'd0, 32'd2);
    send_op(mqto_pkg::CMD_DONE,  4'd0, 32'hFFFF_FFFF);
    send_op(mqto_pkg::CMD_DONE,  4'd0, 32'd1);
    send_op(mqto_pkg::CMD_QUERY, 4'd0, 32'd3);
    send_op(mqto_pkg::CMD_ISSUE, 4'd15, 32'd0);
    send_op(mqto_pkg::CMD_QUERY, 4'd15, 32'd4);
  endtask

  // Fills the last queue to its depth and one beyond, which must flag an
  // overflow. The newest entry is then retired from the tail, and clear
  // empties everything and restarts the counter.
  task automatic test_full_queue();
    repeat (QD + 1) send_op(mqto_pkg::CMD_ISSUE, 4'(NQ - 1), $urandom());
    send_op(mqto_pkg::CMD_DONE, 4'(NQ - 1), ticket_count_m - 1'b1);
    send_op(mqto_pkg::CMD_CLEAR, 4'd9, 32'hFFFF_FFFF);
  endtask

  // Register extremes: zero queues, a value above the number built, and a
  // reduction that hides a queue whose contents must come back intact.
  task automatic test_queue_count_register();
    write_queue_count(4'd0);
    send_op(mqto_pkg::CMD_ISSUE, 4'd0, 32'd0);
    write_queue_count(4'd15);
    send_op(mqto_pkg::CMD_ISSUE, 4'(NQ - 1), 32'd0);
    send_op(mqto_pkg::CMD_ISSUE, 4'(NQ), 32'd0);
    write_queue_count(4'd3);
    send_op(mqto_pkg::CMD_QUERY, 4'(NQ - 1), 32'd2);
    write_queue_count(4'(NQ));
    send_op(mqto_pkg::CMD_QUERY, 4'(NQ - 1), 32'd2);
  endtask

  // Random traffic under one queue count. Most commands address live queues
  // and name tickets that are actually queued; the rest go to unused queue
  // numbers or carry arbitrary tickets.
  task automatic test_random_traffic(input logic [mqto_pkg::CFG_W-1:0] count,
                                     input int n_items);
    int                            roll;
    int                            lim;
    mqto_pkg::cmd_t                op;
    logic [mqto_pkg::QID_W-1:0]    qid;
    logic [mqto_pkg::TICKET_W-1:0] tk;
    write_queue_count(count);
    lim = (int'(count) > NQ) ? NQ : int'(count);
    for (int k = 0; k < n_items; k++) begin
      pace_sender();
      if (lim != 0 && $urandom_range(99) < 85) begin
        qid = 4'($urandom_range(lim - 1));
      end else begin
        qid = 4'($urandom_range(15));
      end
      roll = $urandom_range(99);
      if (roll < 40) begin
        op = mqto_pkg::CMD_ISSUE;
        tk = $urandom();
      end else if (roll < 65) begin
        op = mqto_pkg::CMD_QUERY;
        tk = pick_known_ticket(qid);
      end else if (roll < 97) begin
        op = mqto_pkg::CMD_DONE;
        tk = pick_known_ticket(qid);
      end else begin
        op = mqto_pkg::CMD_CLEAR;
        tk = $urandom();
      end
      send_op(op, qid, tk);
    end
  endtask

  // Main sequence. Reset is held low and released at a falling edge; the
  // predictor starts from the reset state of the block. The counter wrap
  // past the all-ones ticket cannot be reached from the ports in a run of
  // this length, so it is not exercised.
  initial begin
    ticket_count_m  = '0;
    queues_in_use_m = mqto_pkg::QUEUES_IN_USE_RST;
    for (int i = 0; i < NQ; i++) begin
      fill_m[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_queue_order();
    test_full_queue();
    test_queue_count_register();
    test_random_traffic(4'd8, 300);
    test_random_traffic(4'd5, 200);
    test_random_traffic(4'd1, 150);
    test_random_traffic(4'd15, 150);
    test_random_traffic(4'd2, 150);
    test_random_traffic(4'd0, 50);
    test_random_traffic(4'd8, 100);

    // Let the slowest retire finish and make sure no stray reply follows.
    wait_drained();
    repeat (25) @(posedge clk);

    $display("Covered %0d transactions and %0d replies over %0d queue count writes.",
             sent_count, checked_count, cfg_write_count);
    $display("Replies with overflow: %0d, with a waiting ticket: %0d.",
             overflow_count, waiting_count);
    if (mismatch_count == 0) begin
      $display("multi_queue_ticket_order verification clean");
    end else begin
      $display("multi_queue_ticket_order verification failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #5_000_000;
    $display("Timeout with %0d replies still outstanding.", expected_replies.size());
    $display("multi_queue_ticket_order verification failed");
    $finish;
  end

endmodule
